// ----- hdl/fla_pkg.sv -----
// shared types and constants of the free list id allocator
`default_nettype none
package fla_pkg;

  localparam int CAPACITY    = 1024;
  localparam int ENTRY_BYTES = 8;
  localparam int ID_W        = $clog2(CAPACITY);
  localparam int DATA_W      = 64;
  localparam int LIMIT_W     = 11;

  localparam logic [DATA_W-1:0]  DATA_MASK   = {DATA_W{1'b1}} >> (DATA_W - 8 * ENTRY_BYTES);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
  localparam logic [ID_W-1:0]    TOP_MAX     = ID_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_RELEASE,
    CMD_GET,
    CMD_NONE
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_LIMIT,
    STAT_FULL,
    STAT_BADREL
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   entry_id;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [DATA_W-1:0] read_data;
    status_t           status;
  } rsp_t;

  // state update decided by the execute stage
  typedef struct packed {
    logic            stack_we;
    logic            entry_we;
    logic [ID_W-1:0] entry_addr;
    logic [ID_W-1:0] top_next;
    logic [ID_W-1:0] fill_next;
  } upd_t;

endpackage
`default_nettype wire

// ----- hdl/free_list_id_allocator.sv -----
// top level of the free list id allocator
`default_nettype none
// Hands out ids from a stack of free ids and keeps one payload per id. An
// item is taken in the idle state, which reads the free stack and the entry
// store (synchronous memories with one write port and one registered read
// port each); the execute state checks the command, writes back and loads
// the result register. A new item is taken while a result still waits on a
// stalled output, but the execute stage holds until the output register is
// free. Free stack slots above a fill mark read as their own index, so no
// clearing pass runs after reset. The id limit register is written through
// cfg, which is always ready.
module free_list_id_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire fla_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output fla_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fla_pkg::LIMIT_W-1:0]     cfg_data
);

  fla_pkg::state_t               state;
  fla_pkg::state_t               state_next;
  fla_pkg::req_t                 item;
  fla_pkg::rsp_t                 exec_rsp;
  fla_pkg::upd_t                 upd;
  logic [fla_pkg::ID_W-1:0]      top;
  logic [fla_pkg::ID_W-1:0]      fill;
  logic [fla_pkg::LIMIT_W-1:0]   alloc_limit;
  logic [fla_pkg::ID_W-1:0]      stack_rd;
  logic [fla_pkg::DATA_W-1:0]    entry_rd;
  logic                          accept;
  logic                          commit;
  logic                          out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      fla_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = fla_pkg::S_EXEC;
        end
      end
      fla_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = fla_pkg::S_IDLE;
        end
      end
      default: state_next = fla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b0;
    accept    = 1'b0;
    commit    = 1'b0;
    unique case (state)
      fla_pkg::S_IDLE: begin
        accept = req_valid;
      end
      fla_pkg::S_EXEC: begin
        req_stall = 1'b1;
        commit    = out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fla_pkg::S_IDLE;
      rsp_valid   <= 1'b0;
      top         <= '0;
      fill        <= '0;
      alloc_limit <= fla_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid <= 1'b1;
        top       <= upd.top_next;
        fill      <= upd.fill_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        alloc_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (commit) begin
      rsp <= exec_rsp;
    end
  end

  fla_ram #(
    .WIDTH(fla_pkg::ID_W),
    .DEPTH(fla_pkg::CAPACITY)
  ) u_stack (
    .clk  (clk),
    .we   (commit && upd.stack_we),
    .waddr(top),
    .wdata(item.entry_id),
    .re   (accept),
    .raddr(top + 1'b1),
    .rdata(stack_rd)
  );

  fla_ram #(
    .WIDTH(fla_pkg::DATA_W),
    .DEPTH(fla_pkg::CAPACITY)
  ) u_entry (
    .clk  (clk),
    .we   (commit && upd.entry_we),
    .waddr(upd.entry_addr),
    .wdata(item.write_data & fla_pkg::DATA_MASK),
    .re   (accept),
    .raddr(req.entry_id),
    .rdata(entry_rd)
  );

  fla_exec u_exec (
    .item       (item),
    .top        (top),
    .fill       (fill),
    .alloc_limit(alloc_limit),
    .stack_rd   (stack_rd),
    .entry_rd   (entry_rd),
    .rsp        (exec_rsp),
    .upd        (upd)
  );

`ifndef SYNTHESIS
  a_top_below_fill: assert property (@(posedge clk) disable iff (rst) top <= fill)
    else $error("stack top above fill mark");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst) commit |=> rsp_valid)
    else $error("committed item not shown on output");
  a_top_moves_on_commit: assert property (@(posedge clk) disable iff (rst)
      !$past(commit) && !$past(rst) |-> $stable(top))
    else $error("stack top moved without a committed item");
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
      accept |-> state == fla_pkg::S_IDLE && !commit)
    else $error("item accepted while another executes");
`endif

endmodule
`default_nettype wire

// ----- hdl/fla_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fla_exec.sv -----
// execute stage: checks a command and decides result and state update
`default_nettype none
module fla_exec (
  input  wire  fla_pkg::req_t                 item,
  input  wire  logic [fla_pkg::ID_W-1:0]      top,
  input  wire  logic [fla_pkg::ID_W-1:0]      fill,
  input  wire  logic [fla_pkg::LIMIT_W-1:0]   alloc_limit,
  input  wire  logic [fla_pkg::ID_W-1:0]      stack_rd,
  input  wire  logic [fla_pkg::DATA_W-1:0]    entry_rd,
  output fla_pkg::rsp_t                       rsp,
  output fla_pkg::upd_t                       upd
);

  logic [fla_pkg::ID_W-1:0] slot;
  logic [fla_pkg::ID_W-1:0] free_id;

  // slots above the fill mark were never written, so their id is taken as their own index
  assign slot    = top + 1'b1;
  assign free_id = (slot > fill) ? slot : stack_rd;

  always_comb begin
    rsp.result_id  = item.entry_id;
    rsp.read_data  = '0;
    rsp.status     = fla_pkg::STAT_OK;
    upd.stack_we   = 1'b0;
    upd.entry_we   = 1'b0;
    upd.entry_addr = free_id;
    upd.top_next   = top;
    upd.fill_next  = fill;
    case (item.cmd)
      fla_pkg::CMD_INSERT: begin
        rsp.result_id = '0;
        if ({1'b0, top} == alloc_limit) begin
          rsp.status = fla_pkg::STAT_LIMIT;
        end else if (top == fla_pkg::TOP_MAX) begin
          rsp.status = fla_pkg::STAT_FULL;
        end else begin
          rsp.result_id = free_id;
          upd.entry_we  = 1'b1;
          upd.top_next  = slot;
          if (slot > fill) begin
            upd.fill_next = slot;
          end
        end
      end
      fla_pkg::CMD_RELEASE: begin
        if (top == '0 || {1'b0, item.entry_id} >= alloc_limit) begin
          rsp.status = fla_pkg::STAT_BADREL;
        end else begin
          rsp.read_data = entry_rd;
          upd.stack_we  = 1'b1;
          upd.top_next  = top - 1'b1;
        end
      end
      fla_pkg::CMD_GET: begin
        rsp.read_data = entry_rd;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sim/free_list_id_allocator_tb.sv -----
// self-checking testbench for the free list id allocator
module free_list_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fla_pkg::*;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam int LONG_HOLD = 80;

  typedef struct {
    bit   is_cfg;
    int   limit;
    req_t item;
    bit   typed;
    rsp_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  // predicted state of the allocator
  logic [ID_W-1:0]    free_ids [CAPACITY];
  logic [ID_W-1:0]    top_ptr;
  logic [DATA_W-1:0]  payload [CAPACITY];
  bit                 has_payload [CAPACITY];
  logic [LIMIT_W-1:0] limit_reg;
  logic [ID_W-1:0]    live_ids [$];
  logic [ID_W-1:0]    written_ids [$];

  rsp_t awaited [$];
  int   n_err = 0;
  int   n_results = 0;
  int   burst_left = 0;
  int   gap = 0;

  free_list_id_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (n_err < 40) $display("mismatch at %0t ns: %s", $time, what);
    n_err++;
  endtask

  // expected response of one accepted item, advancing the predicted state
  function automatic rsp_t alloc_response(input req_t it);
    rsp_t r;
    logic [ID_W-1:0] id;
    r.result_id = it.entry_id;
    r.read_data = '0;
    r.status    = STAT_OK;
    case (it.cmd)
      CMD_INSERT: begin
        r.result_id = '0;
        if (LIMIT_W'(top_ptr) == limit_reg) begin
          r.status = STAT_LIMIT;
        end else if (int'(top_ptr) + 1 >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          top_ptr = top_ptr + 1'b1;
          id = free_ids[top_ptr];
          payload[id] = it.write_data & DATA_MASK;
          if (!has_payload[id]) written_ids.push_back(id);
          has_payload[id] = 1'b1;
          live_ids.push_back(id);
          r.result_id = id;
        end
      end
      CMD_RELEASE: begin
        if (top_ptr == '0 || LIMIT_W'(it.entry_id) >= limit_reg) begin
          r.status = STAT_BADREL;
        end else begin
          free_ids[top_ptr] = it.entry_id;
          top_ptr = top_ptr - 1'b1;
          r.read_data = payload[it.entry_id];
          for (int k = 0; k < live_ids.size(); k++) begin
            if (live_ids[k] == it.entry_id) begin
              live_ids.delete(k);
              break;
            end
          end
        end
      end
      CMD_GET: r.read_data = payload[it.entry_id];
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t pick_request(input int ins_pct, input int rel_pct);
    req_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.write_data = {$urandom, $urandom};
    it.entry_id = ID_W'($urandom_range(0, CAPACITY - 1));
    if (roll < ins_pct) begin
      it.cmd = CMD_INSERT;
    end else if (roll < ins_pct + rel_pct) begin
      it.cmd = CMD_RELEASE;
      if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
        it.entry_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    end else if (roll >= 96) begin
      it.cmd = CMD_NONE;
    end else begin
      it.cmd = CMD_GET;
    end
    // reads that return data must hit an entry that has been written
    if ((it.cmd == CMD_GET || (it.cmd == CMD_RELEASE && top_ptr != '0 &&
         LIMIT_W'(it.entry_id) < limit_reg)) && !has_payload[it.entry_id]) begin
      if (written_ids.size() == 0) it.cmd = CMD_INSERT;
      else it.entry_id = written_ids[$urandom_range(0, written_ids.size() - 1)];
    end
    return it;
  endfunction

  function automatic step_t cmd_row(input cmd_t c, input int e, input logic [DATA_W-1:0] d);
    step_t s;
    s.is_cfg = 1'b0;
    s.limit = 0;
    s.item.cmd = c;
    s.item.entry_id = ID_W'(e);
    s.item.write_data = d;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t typed_row(input cmd_t c, input int e, input logic [DATA_W-1:0] d,
                                      input int id, input logic [DATA_W-1:0] rd,
                                      input status_t st);
    step_t s;
    s = cmd_row(c, e, d);
    s.typed = 1'b1;
    s.want.result_id = ID_W'(id);
    s.want.read_data = rd;
    s.want.status = st;
    return s;
  endfunction

  function automatic step_t limit_row(input int v);
    step_t s;
    s = cmd_row(CMD_NONE, 0, '0);
    s.is_cfg = 1'b1;
    s.limit = v;
    return s;
  endfunction

  // sender works in bursts; a new burst may start after a gap
  task automatic offer(input req_t it, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (req_stall);
    predicted = alloc_response(it);
    awaited.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= LIMIT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = LIMIT_W'(v);
  endtask

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result id %0d with nothing pending", rsp.result_id));
      end else begin
        want = awaited.pop_front();
        if (rsp.result_id !== want.result_id)
          report_mismatch($sformatf("result_id %0d, want %0d", rsp.result_id, want.result_id));
        if (rsp.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h", rsp.read_data, want.read_data));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
      end
    end
  end

  // receiver stall pattern: stretches of none, light and heavy stalling
  initial begin : rsp_side
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_results >= 60) begin
        // long hold so the block backs up and stalls its input
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      mode_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    step_t plan [$];
    int ph_limit [7];
    int ph_items [7];
    int ph_ins [7];
    int ph_rel [7];
    int lim;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      free_ids[i] = ID_W'(i);
      payload[i] = '0;
      has_payload[i] = 1'b0;
    end
    top_ptr = '0;
    limit_reg = LIMIT_RESET;

    plan = '{
      typed_row(CMD_INSERT, 0, ALL_ONES, 1, '0, STAT_OK),
      typed_row(CMD_INSERT, 1023, '0, 2, '0, STAT_OK),
      typed_row(CMD_GET, 1, '0, 1, ALL_ONES, STAT_OK),
      typed_row(CMD_GET, 2, ALL_ONES, 2, '0, STAT_OK),
      typed_row(CMD_RELEASE, 1, '0, 1, ALL_ONES, STAT_OK),
      cmd_row(CMD_INSERT, 0, 64'hA5A5_A5A5_A5A5_A5A5),
      typed_row(CMD_NONE, 1023, ALL_ONES, 1023, '0, STAT_OK),
      cmd_row(CMD_RELEASE, 2, '0),
      cmd_row(CMD_RELEASE, 1, ALL_ONES),
      // empty stack
      typed_row(CMD_RELEASE, 1, '0, 1, '0, STAT_BADREL),
      typed_row(CMD_RELEASE, 1023, ALL_ONES, 1023, '0, STAT_BADREL),
      cmd_row(CMD_GET, 1, '0),
      cmd_row(CMD_INSERT, 512, 64'h0123_4567_89AB_CDEF),
      limit_row(2),
      cmd_row(CMD_INSERT, 0, ALL_ONES),
      typed_row(CMD_INSERT, 0, ALL_ONES, 0, '0, STAT_LIMIT),
      typed_row(CMD_RELEASE, 2, '0, 2, '0, STAT_BADREL),
      limit_row(0),
      // top above the limit, so insert still goes through
      cmd_row(CMD_INSERT, 0, 64'h8000_0000_0000_0001),
      typed_row(CMD_RELEASE, 0, '0, 0, '0, STAT_BADREL),
      limit_row(1024),
      cmd_row(CMD_RELEASE, 3, '0),
      cmd_row(CMD_RELEASE, 2, '0),
      cmd_row(CMD_RELEASE, 1, '0),
      limit_row(0),
      typed_row(CMD_INSERT, 0, ALL_ONES, 0, '0, STAT_LIMIT),
      limit_row(1024)
    };

    // random phases; a negative limit means pick one at random
    // the fourth phase inserts nearly always so the list runs full
    ph_limit = '{1024, 3, -1, 1024, 1023, 0, -1};
    ph_items = '{40, 30, 30, 1060, 20, 20, 30};
    ph_ins   = '{40, 45, 40, 98, 40, 40, 30};
    ph_rel   = '{35, 35, 35, 0, 40, 30, 45};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_limit(plan[i].limit);
      else offer(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 7; p++) begin
      lim = (ph_limit[p] < 0) ? $urandom_range(1, 1022) : ph_limit[p];
      write_limit(lim);
      repeat (ph_items[p]) offer(pick_request(ph_ins[p], ph_rel[p]), 1'b0, '0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (n_err == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- free_list_id_allocator.f -----
hdl/fla_pkg.sv
hdl/fla_ram.sv
hdl/fla_exec.sv
hdl/free_list_id_allocator.sv
sim/free_list_id_allocator_tb.sv
